[design/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// types and constants shared by the process table scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;
	localparam logic [1:0] OP_SLEEP    = 2'd0;
	localparam logic [1:0] OP_SCHEDULE = 2'd1;
	localparam logic [1:0] OP_CREATE   = 2'd2;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_SLEEP = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_RUN  = 2'd1;
	localparam logic [1:0] STAT_NO_FREE = 2'd2;

	localparam logic [14:0] PID_MAX = 15'h7fff;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         current_slot;
		logic [15:0]        channel;
		logic signed [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         slot;
		logic [14:0]        new_pid;
		logic signed [7:0]  current_priority;
	} rsp_t;

	// fields one cell passes to the next when the ring shifts
	typedef struct packed {
		logic [1:0]        state;
		logic signed [7:0] prio;
		logic [14:0]       pid;
	} cell_out_t;

	// command broadcast from the control to every cell
	typedef struct packed {
		logic        shift;
		logic        wr_sleep;
		logic        wr_create;
		logic [1:0]  sleep_state;
		logic signed [7:0] sleep_prio;
		logic [15:0] sleep_chan;
		logic [14:0] new_pid;
		logic [14:0] parent_pid;
	} cell_cmd_t;
endpackage
`default_nettype wire

[design/pts_cell.sv]
// ----------------------------------------------------------------------------
// pts_cell
// one process slot; rotates its contents to the next cell when shift is set
// ----------------------------------------------------------------------------
`default_nettype none
module pts_cell import pts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire logic      sel_sleep,
	input  wire logic      sel_create,
	input  wire cell_out_t prev,
	input  wire logic [15:0] prev_chan,
	input  wire logic [14:0] prev_ppid,
	output cell_out_t      cur,
	output logic [15:0]    chan,
	output logic [14:0]    ppid
);
	cell_out_t   d_q;
	logic [15:0] chan_q;
	logic [14:0] ppid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q    <= '0;
			chan_q <= '0;
			ppid_q <= '0;
		end else if (cmd.shift) begin
			d_q    <= prev;
			chan_q <= prev_chan;
			ppid_q <= prev_ppid;
		end else if (cmd.wr_sleep && sel_sleep) begin
			d_q.state <= cmd.sleep_state;
			d_q.prio  <= cmd.sleep_prio;
			chan_q    <= cmd.sleep_chan;
		end else if (cmd.wr_create && sel_create) begin
			d_q.state <= ST_RUN;
			d_q.pid   <= cmd.new_pid;
			ppid_q    <= cmd.parent_pid;
		end
	end

	assign cur  = d_q;
	assign chan = chan_q;
	assign ppid = ppid_q;
endmodule
`default_nettype wire

[design/process_table_scheduler.sv]
// ----------------------------------------------------------------------------
// process_table_scheduler
// slot table held in a ring of cells; each schedule or create pass rotates the ring once
// ----------------------------------------------------------------------------
// a sleep writes its slot directly; a schedule makes one pass of the ring;
// a create makes one pass per candidate pid, advancing past pids already in use
// one request at a time: in_stall holds while busy or while a result is pending
// reset clears every slot to free with zero fields, cursor and pid counter
`default_nettype none
module process_table_scheduler import pts_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      out_data
);
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] pos_q;        // slot index held at cell 0
	logic [IW-1:0] cursor_q;
	logic signed [7:0] picked_q;
	logic [14:0]   last_pid_q;
	logic [14:0]   cand_q;
	logic          hit_q;
	logic          found_q;
	logic signed [8:0] best_q;
	logic [IW-1:0] pick_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic [14:0]   ppid_val_q;
	logic          out_valid_q;
	rsp_t          out_q;
	rsp_t          done_rsp;

	cell_out_t   c_out [NUM_SLOTS];
	logic [15:0] c_chan [NUM_SLOTS];
	logic [14:0] c_ppid [NUM_SLOTS];
	cell_cmd_t   cmd;

	logic cur_ok;
	assign cur_ok = 32'(in_data.current_slot) < NUM_SLOTS;

	// scanned slot: cell 0 holds pos_q; the index of the slot visited this cycle
	logic [IW-1:0] idx;
	assign idx = pos_q;

	logic [14:0] adv_cand;
	assign adv_cand = (cand_q == PID_MAX) ? 15'd1 : cand_q + 15'd1;

	logic pass_end;
	assign pass_end = cnt_q == CW'(NUM_SLOTS - 1);

	logic do_accept;
	assign do_accept = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE || out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.shift       = state_q == S_SCAN;
		cmd.wr_sleep    = do_accept && in_data.operation == OP_SLEEP && cur_ok;
		cmd.sleep_state = in_data.priority_req[7] ? ST_SLEEP : ST_WAIT;
		cmd.sleep_prio  = in_data.priority_req;
		cmd.sleep_chan  = in_data.channel;
		cmd.wr_create   = state_q == S_DONE && req_q.operation == OP_CREATE && free_q;
		cmd.new_pid     = cand_q;
		// a parent that is the new slot itself sees the new pid
		cmd.parent_pid  = (free_idx_q == req_q.current_slot[IW-1:0]) ? cand_q : ppid_val_q;
	end

	always_comb begin
		done_rsp = '0;
		if (req_q.operation == OP_SCHEDULE) begin
			if (found_q) begin
				done_rsp.slot             = 4'(pick_q);
				done_rsp.current_priority = best_q[7:0];
			end else begin
				done_rsp.status = STAT_NO_RUN;
			end
		end else if (req_q.operation == OP_CREATE) begin
			if (free_q) begin
				done_rsp.slot    = 4'(free_idx_q);
				done_rsp.new_pid = cand_q;
			end else begin
				done_rsp.status = STAT_NO_FREE;
			end
		end
	end

	// ring rotates toward lower index; with pos_q at cell 0, slot s sits at cell s-pos_q
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		localparam int N = (g + 1) % NUM_SLOTS;
		logic ss, sc;
		assign ss = IW'(g) == IW'(in_data.current_slot[IW-1:0] - pos_q);
		assign sc = IW'(g) == IW'(free_idx_q - pos_q);
		pts_cell u_cell (
			.clk, .arst_n, .cmd,
			.sel_sleep(ss), .sel_create(sc),
			.prev(c_out[N]), .prev_chan(c_chan[N]), .prev_ppid(c_ppid[N]),
			.cur(c_out[g]), .chan(c_chan[g]), .ppid(c_ppid[g])
		);
	end

	// round-robin order from cursor+1 versus pos order from 0: rank by distance
	logic [IW-1:0] rank;
	assign rank = IW'(idx - cursor_q - IW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			cursor_q    <= '0;
			picked_q    <= '0;
			last_pid_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (do_accept) begin
						req_q <= in_data;
						cnt_q <= '0;
						hit_q <= 1'b0;
						found_q <= 1'b0;
						best_q <= 9'sd128;
						free_q <= 1'b0;
						cand_q <= (last_pid_q == PID_MAX) ? 15'd1 : last_pid_q + 15'd1;
						ppid_val_q <= '0;
						if (in_data.operation == OP_SCHEDULE ||
							in_data.operation == OP_CREATE)
							state_q <= S_SCAN;
						else
							state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					pos_q <= (32'(pos_q) == NUM_SLOTS - 1) ? '0 : pos_q + IW'(1);
					cnt_q <= pass_end ? '0 : cnt_q + CW'(1);
					if (req_q.operation == OP_SCHEDULE) begin
						// earliest rank wins ties; ranks are visited out of order
						if (c_out[0].state == ST_RUN &&
							(9'(c_out[0].prio) < best_q ||
							 (9'(c_out[0].prio) == best_q && found_q &&
							  rank < IW'(pick_q - cursor_q - IW'(1))))) begin
							best_q  <= 9'(c_out[0].prio);
							pick_q  <= idx;
							found_q <= 1'b1;
						end
						if (pass_end) state_q <= S_DONE;
					end else begin
						if (c_out[0].pid == cand_q) hit_q <= 1'b1;
						if (c_out[0].state == ST_FREE &&
							(!free_q || idx < free_idx_q)) begin
							free_q     <= 1'b1;
							free_idx_q <= idx;
						end
						if (32'(idx) == 32'(req_q.current_slot))
							ppid_val_q <= c_out[0].pid;
						if (pass_end) begin
							if (hit_q || c_out[0].pid == cand_q) begin
								cand_q <= adv_cand;
								hit_q  <= 1'b0;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_DONE: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					out_q       <= done_rsp;
					if (req_q.operation == OP_SCHEDULE) begin
						if (found_q) begin
							cursor_q <= pick_q;
							picked_q <= best_q[7:0];
						end
					end else if (req_q.operation == OP_CREATE) begin
						last_pid_q <= cand_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid) else $error("no result after done");
	a_pos_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> pos_q == '0) else $error("ring not aligned");
endmodule
`default_nettype wire
